// ===== rtl/sfp_pkg.sv =====
package sfp_pkg;

  // Longest frame on the wire, header and BCC included.
  localparam int unsigned MAX_FRAME_BYTES = 1032;
  // Header, address, two length bytes, command and BCC.
  localparam int unsigned FRAME_OVERHEAD  = 7;

  localparam logic [7:0]  SYNC_BYTE     = 8'h5A;
  localparam logic [15:0] LEN_CAP       = 16'(MAX_FRAME_BYTES - FRAME_OVERHEAD);
  localparam logic [10:0] FRAME_LEN_MAX = 11'h7FF;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDRESS     = 1'b0,
    CFG_MAX_DATA_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_ADDR  = 3'd2,
    PH_LENHI = 3'd3,
    PH_LENLO = 3'd4,
    PH_CMD   = 3'd5,
    PH_DATA  = 3'd6,
    PH_BCC   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    V_READY = 2'd0,
    V_SKIP  = 2'd1,
    V_FAKE  = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [10:0] frame_length;
    logic [7:0]  command;
    logic [7:0]  frame_address;
  } result_t;

endpackage

// ===== rtl/sfp_parser.sv =====
module sfp_parser
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_fire,
  input  logic [7:0]  rx_byte,
  input  logic [1:0]  own_address,
  input  logic [10:0] max_data_length,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase_r,     phase_nxt;
  logic [15:0] pay_len_r,   pay_len_nxt;
  logic [10:0] left_r,      left_nxt;
  logic [7:0]  check_r,     check_nxt;
  logic [7:0]  addr_r,      addr_nxt;
  logic [7:0]  cmd_r,       cmd_nxt;

  logic [15:0] limit;
  logic [16:0] len_sum;
  logic [10:0] len_sat;
  logic        addr_other;

  // Effective length limit: the smaller of the register and the build cap.
  assign limit      = ({5'd0, max_data_length} < LEN_CAP) ? {5'd0, max_data_length} : LEN_CAP;
  assign len_sum    = {1'b0, pay_len_r} + 17'(FRAME_OVERHEAD);
  assign len_sat    = (len_sum > {6'd0, FRAME_LEN_MAX}) ? FRAME_LEN_MAX : len_sum[10:0];
  assign addr_other = (addr_r != 8'd0) && (addr_r != {6'd0, own_address});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEAD1;
      pay_len_r <= '0;
      left_r    <= '0;
      check_r   <= '0;
      addr_r    <= '0;
      cmd_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pay_len_r <= pay_len_nxt;
      left_r    <= left_nxt;
      check_r   <= check_nxt;
      addr_r    <= addr_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    pay_len_nxt = pay_len_r;
    left_nxt    = left_r;
    check_nxt   = check_r;
    addr_nxt    = addr_r;
    cmd_nxt     = cmd_r;
    res_valid   = 1'b0;
    res.verdict       = V_READY;
    res.frame_length  = len_sat;
    res.command       = cmd_r;
    res.frame_address = addr_r;

    if (byte_fire) begin
      unique case (phase_r)
        PH_HEAD1: begin
          if (rx_byte == SYNC_BYTE) phase_nxt = PH_HEAD2;
        end
        PH_HEAD2: begin
          phase_nxt = (rx_byte == SYNC_BYTE) ? PH_ADDR : PH_HEAD1;
        end
        PH_ADDR: begin
          addr_nxt  = rx_byte;
          check_nxt = rx_byte;
          phase_nxt = PH_LENHI;
        end
        PH_LENHI: begin
          pay_len_nxt = {rx_byte, 8'h00};
          check_nxt   = check_r ^ rx_byte;
          phase_nxt   = PH_LENLO;
        end
        PH_LENLO: begin
          pay_len_nxt = {pay_len_r[15:8], rx_byte};
          check_nxt   = check_r ^ rx_byte;
          phase_nxt   = PH_CMD;
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          check_nxt = check_r ^ rx_byte;
          if (pay_len_r > limit) begin
            // overlong length: fake right away, command is this byte
            res_valid        = 1'b1;
            res.verdict      = V_FAKE;
            res.frame_length = '0;
            res.command      = rx_byte;
            phase_nxt        = PH_HEAD1;
          end else begin
            left_nxt  = pay_len_r[10:0];
            phase_nxt = (pay_len_r[10:0] == 11'd0) ? PH_BCC : PH_DATA;
          end
        end
        PH_DATA: begin
          check_nxt = check_r ^ rx_byte;
          left_nxt  = left_r - 11'd1;
          if (left_nxt == 11'd0) phase_nxt = PH_BCC;
        end
        PH_BCC: begin
          res_valid = 1'b1;
          phase_nxt = PH_HEAD1;
          // address check wins over the BCC check
          if (addr_other) begin
            res.verdict = V_SKIP;
          end else if (check_r != rx_byte) begin
            res.verdict      = V_FAKE;
            res.frame_length = '0;
          end else begin
            res.verdict = V_READY;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/sfp_out_queue.sv =====
module sfp_out_queue
  import sfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  result_t    slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign has_room  = (count_r != 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/serial_frame_probe_top.sv =====
// Serial frame probe. Takes one received byte per input transaction and
// tracks frames of the form 5A 5A, address, 16-bit big-endian length,
// command, data, BCC (XOR of address through last data byte). Each finished
// frame gives one result transaction: ready, skip (address neither 0 nor
// own_address; checked before the BCC) or fake (length above the limit,
// which ends the frame at the command byte, or a bad BCC; length reads 0).
// Rate: one byte per clock unless stalled. The byte updates the parser state in
// the cycle it is accepted and any result lands in a two-entry output queue,
// visible on out_valid the next cycle. in_ready depends only on that queue:
// it drops when both entries hold unread results, so a slow consumer can
// stall the input but never costs bytes. Configuration writes are always
// taken (cfg_ready is high) and should only happen while the block is idle.
module serial_frame_probe_top
  import sfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_verdict,
  output logic [10:0]           out_frame_length,
  output logic [7:0]            out_command,
  output logic [7:0]            out_frame_address,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]  own_address_r;
  logic [10:0] max_len_r;
  logic        byte_fire;
  logic        res_valid;
  result_t     res;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign byte_fire = in_valid && in_ready;

  // config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= 2'd0;
      max_len_r     <= 11'd1025;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OWN_ADDRESS:     own_address_r <= cfg_wdata[1:0];
        CFG_MAX_DATA_LENGTH: max_len_r     <= cfg_wdata[10:0];
      endcase
    end
  end

  sfp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_fire       (byte_fire),
    .rx_byte         (in_rx_byte),
    .own_address     (own_address_r),
    .max_data_length (max_len_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  // at most one result per byte, so room in the queue is all in_ready needs
  sfp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_room  (in_ready),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (head)
  );

  assign out_verdict       = head.verdict;
  assign out_frame_length  = head.frame_length;
  assign out_command       = head.command;
  assign out_frame_address = head.frame_address;

endmodule

// ===== rtl/sfp_checker.sv =====
module sfp_checker
  import sfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_verdict,
  input logic [10:0] out_frame_length,
  input logic [7:0]  out_command,
  input logic [7:0]  out_frame_address
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_verdict) && $stable(out_frame_length)
      && $stable(out_command) && $stable(out_frame_address))
    else $error("stalled result payload changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_len_vs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_verdict == V_FAKE) && (out_frame_length == 11'd0))
      || ((out_verdict != V_FAKE) && (out_verdict != 2'd3)
          && (out_frame_length >= 11'd7)))
    else $error("frame length does not fit verdict");

endmodule

bind serial_frame_probe_top sfp_checker u_sfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_verdict       (out_verdict),
  .out_frame_length  (out_frame_length),
  .out_command       (out_command),
  .out_frame_address (out_frame_address)
);
